### hdl/vtpd_pkg.sv
// ----------------------------------------------------------------------------
// vtpd_pkg
// Shared widths, word types and reset matrix for the vertex transform block.
// ----------------------------------------------------------------------------
package vtpd_pkg;

	localparam int unsigned COORD_W  = 32;
	localparam int unsigned PROD_W   = 2 * COORD_W;
	localparam int unsigned SUM_W    = PROD_W + 2;
	localparam int unsigned FRAC_W   = 16;
	localparam int unsigned NUM_REGS = 8;
	localparam int unsigned REG_W    = 64;
	localparam int unsigned IDX_W    = $clog2(NUM_REGS);
	localparam int unsigned ADDR_W   = IDX_W + 3;

	// divider: 32 quotient bits, two per stage
	localparam int unsigned QUO_W          = 32;
	localparam int unsigned DIV_STEPS      = 2;
	localparam int unsigned DIV_STAGES     = QUO_W / DIV_STEPS;

	localparam int unsigned MID_DEPTH_DEF = 8;
	localparam int unsigned OUT_DEPTH_DEF = 32;

	// identity matrix
	localparam logic [REG_W-1:0] REG_RESET [NUM_REGS] = '{
		64'h0000_0000_0001_0000, 64'h0,
		64'h0001_0000_0000_0000, 64'h0,
		64'h0,                   64'h0000_0000_0001_0000,
		64'h0,                   64'h0001_0000_0000_0000
	};

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic [COORD_W-1:0] entry_t;
	typedef entry_t [3:0][3:0] mat_t;

	typedef struct packed {
		logic [PROD_W-1:0] mag;
		logic              neg;
	} lane_t;

	typedef struct packed {
		lane_t [2:0]        lane;
		logic               wneg;
		logic [COORD_W-1:0] wmag;
		coord_t             w;
		logic               zero;
	} mid_word_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
		coord_t w;
		logic   zero;
	} out_word_t;

endpackage

### hdl/vtpd_fifo.sv
// ----------------------------------------------------------------------------
// vtpd_fifo
// Register FIFO with first-word fall-through and an occupancy count.
// ----------------------------------------------------------------------------
module vtpd_fifo #(
	parameter int unsigned DEPTH = 8,
	parameter int unsigned WIDTH = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  logic [WIDTH-1:0]           wr_data,
	input  logic                       rd_en,
	output logic [WIDTH-1:0]           rd_data,
	output logic                       empty,
	output logic [$clog2(DEPTH+1)-1:0] count
);
	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH+1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	function automatic logic [PTR_W-1:0] nxt(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH-1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= nxt(wr_ptr_q);
			end
			if (rd_en) begin
				rd_ptr_q <= nxt(rd_ptr_q);
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	assign rd_data = mem_q[rd_ptr_q];
	assign empty   = (cnt_q == '0);
	assign count   = cnt_q;

endmodule

### hdl/vtpd_front.sv
// ----------------------------------------------------------------------------
// vtpd_front
// Matrix multiply, w rounding and classification of each point.
// ----------------------------------------------------------------------------
module vtpd_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_vld,
	input  vtpd_pkg::coord_t    in_x,
	input  vtpd_pkg::coord_t    in_y,
	input  vtpd_pkg::coord_t    in_z,
	input  vtpd_pkg::mat_t      mat,
	output logic                out_vld,
	output vtpd_pkg::mid_word_t out_word
);
	import vtpd_pkg::*;

	localparam int unsigned T_W = SUM_W - FRAC_W;
	localparam logic signed [T_W-1:0] T_MAX = {{(T_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
	localparam logic signed [T_W-1:0] T_MIN = {{(T_W-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}};

	coord_t                    coord [3];
	logic signed [PROD_W-1:0]  prod_s1 [3][4];
	coord_t                    bias_s1 [4];
	logic signed [SUM_W-1:0]   sum_s2 [4];
	logic                      vld_s1, vld_s2, vld_s3;
	mid_word_t                 word_s3, word_c;

	assign coord[0] = in_x;
	assign coord[1] = in_y;
	assign coord[2] = in_z;

	always_ff @(posedge clk) begin
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 3; r++) begin
				prod_s1[r][c] <= coord[r] * $signed(mat[r][c]);
			end
			bias_s1[c] <= $signed(mat[3][c]);
			sum_s2[c]  <= SUM_W'(prod_s1[0][c]) + SUM_W'(prod_s1[1][c])
				+ SUM_W'(prod_s1[2][c]) + (SUM_W'(bias_s1[c]) <<< FRAC_W);
		end
		word_s3 <= word_c;
	end

	// w = floor(S4 / 2^16), saturated; coordinates as sign and magnitude
	always_comb begin
		logic signed [T_W-1:0]   t;
		logic signed [SUM_W-1:0] nsum;
		t = sum_s2[3][SUM_W-1:FRAC_W];
		if (t > T_MAX) begin
			word_c.w = coord_t'(T_MAX[COORD_W-1:0]);
		end else if (t < T_MIN) begin
			word_c.w = coord_t'(T_MIN[COORD_W-1:0]);
		end else begin
			word_c.w = t[COORD_W-1:0];
		end
		word_c.wneg = sum_s2[3][SUM_W-1];
		word_c.wmag = word_c.wneg ? (COORD_W'(0) - word_c.w) : word_c.w;
		word_c.zero = (word_c.w == '0);
		for (int j = 0; j < 3; j++) begin
			nsum = -sum_s2[j];
			word_c.lane[j].neg = sum_s2[j][SUM_W-1];
			word_c.lane[j].mag = sum_s2[j][SUM_W-1] ? nsum[PROD_W-1:0] : sum_s2[j][PROD_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	assign out_vld  = vld_s3;
	assign out_word = word_s3;

endmodule

### hdl/vtpd_div.sv
// ----------------------------------------------------------------------------
// vtpd_div
// Pipelined restoring divider, 64 by 32 bits, 32-bit quotient.
// ----------------------------------------------------------------------------
module vtpd_div (
	input  logic                          clk,
	input  logic [vtpd_pkg::PROD_W-1:0]   num,
	input  logic [vtpd_pkg::COORD_W-1:0]  den,
	output logic [vtpd_pkg::QUO_W-1:0]    quo
);
	import vtpd_pkg::*;

	// valid only when num[63:32] < den
	logic [COORD_W-1:0] rem_s [DIV_STAGES+1];
	logic [QUO_W-1:0]   low_s [DIV_STAGES+1];
	logic [COORD_W-1:0] den_s [DIV_STAGES+1];

	assign rem_s[0] = num[PROD_W-1:QUO_W];
	assign low_s[0] = num[QUO_W-1:0];
	assign den_s[0] = den;

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		logic [COORD_W-1:0] rem_c;
		logic [QUO_W-1:0]   low_c;

		always_comb begin
			logic [COORD_W:0] r;
			rem_c = rem_s[k];
			low_c = low_s[k];
			for (int i = 0; i < DIV_STEPS; i++) begin
				r = {rem_c, low_c[QUO_W-1]};
				if (r >= {1'b0, den_s[k]}) begin
					r = r - {1'b0, den_s[k]};
					low_c = {low_c[QUO_W-2:0], 1'b1};
				end else begin
					low_c = {low_c[QUO_W-2:0], 1'b0};
				end
				rem_c = r[COORD_W-1:0];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k+1] <= rem_c;
			low_s[k+1] <= low_c;
			den_s[k+1] <= den_s[k];
		end
	end

	assign quo = low_s[DIV_STAGES];

endmodule

### hdl/vtpd_back.sv
// ----------------------------------------------------------------------------
// vtpd_back
// Perspective divide of x, y, z by w with sign and saturation.
// ----------------------------------------------------------------------------
module vtpd_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_vld,
	input  vtpd_pkg::mid_word_t in_word,
	output logic                out_vld,
	output vtpd_pkg::out_word_t out_word
);
	import vtpd_pkg::*;

	typedef struct packed {
		logic [2:0] neg;
		logic [2:0] ovf;
		logic       wneg;
		coord_t     w;
		logic       zero;
	} side_t;

	mid_word_t          word_s1;
	logic [2:0]         ovf_s1;
	side_t              side_d [DIV_STAGES+1];
	logic [QUO_W-1:0]   quo [3];
	logic [DIV_STAGES:0] vld_d;
	out_word_t          word_q;
	logic               vld_q;
	coord_t             res [3];

	always_ff @(posedge clk) begin
		word_s1 <= in_word;
		for (int j = 0; j < 3; j++) begin
			// quotient needs more than 32 bits
			ovf_s1[j] <= in_word.lane[j].mag[PROD_W-1:QUO_W] >= in_word.wmag;
		end
	end

	assign side_d[0] = '{neg: {word_s1.lane[2].neg, word_s1.lane[1].neg, word_s1.lane[0].neg},
		ovf: ovf_s1, wneg: word_s1.wneg, w: word_s1.w, zero: word_s1.zero};

	for (genvar j = 0; j < 3; j++) begin : g_lane
		vtpd_div u_div (
			.clk (clk),
			.num (word_s1.lane[j].mag),
			.den (word_s1.wmag),
			.quo (quo[j])
		);
	end

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_side
		always_ff @(posedge clk) begin
			side_d[k+1] <= side_d[k];
		end
	end

	always_comb begin
		side_t s;
		s = side_d[DIV_STAGES];
		for (int j = 0; j < 3; j++) begin
			if (s.zero) begin
				res[j] = '0;
			end else if (s.neg[j] != s.wneg) begin
				if (s.ovf[j] || quo[j] > 32'h8000_0000) begin
					res[j] = 32'sh8000_0000;
				end else begin
					res[j] = QUO_W'(0) - quo[j];
				end
			end else begin
				if (s.ovf[j] || quo[j] > 32'h7FFF_FFFF) begin
					res[j] = 32'sh7FFF_FFFF;
				end else begin
					res[j] = quo[j];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		word_q <= '{x: res[0], y: res[1], z: res[2], w: side_d[DIV_STAGES].w,
			zero: side_d[DIV_STAGES].zero};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_d <= '0;
			vld_q <= 1'b0;
		end else begin
			vld_d <= {vld_d[DIV_STAGES-1:0], in_vld};
			vld_q <= vld_d[DIV_STAGES];
		end
	end

	assign out_vld  = vld_q;
	assign out_word = word_q;

endmodule

### hdl/vertex_transform_perspective_divide.sv
// ----------------------------------------------------------------------------
// vertex_transform_perspective_divide
// Q16.16 4x4 vertex transform with perspective divide, queue-style ports.
// ----------------------------------------------------------------------------
// Usage:
//  - Input words (in_x, in_y, in_z) go in with push while full is low. The
//    point is taken as (x, y, z, 1) times the matrix in the eight 64-bit APB
//    registers (register i at byte address 8*i, column pairs low/high).
//  - Result words sit on out_x/y/z/w and zero_w while empty is low; pop takes
//    the oldest one.
//  - Throughput: one word per cycle in both directions, while full stays low
//    on the input side and empty stays low on the output side.
//  - Front end (multiply, accumulate, round w registers) feeds a mid queue;
//    the back end (16-stage radix-2 divider plus setup and saturation
//    registers) drains it into the result queue. Each side issues only when
//    it holds credit for space downstream, so neither pipeline ever stalls.
//  - When the reader stops popping the result queue fills, the back end stops
//    issuing, then the mid queue fills and full rises. Nothing is dropped.
//  - Reset loads the identity matrix and empties both queues; no clearing
//    pass is needed.
// ----------------------------------------------------------------------------
module vertex_transform_perspective_divide #(
	parameter int unsigned MID_DEPTH = vtpd_pkg::MID_DEPTH_DEF,
	parameter int unsigned OUT_DEPTH = vtpd_pkg::OUT_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [vtpd_pkg::ADDR_W-1:0]   paddr,
	input  logic [vtpd_pkg::REG_W-1:0]    pwdata,
	output logic [vtpd_pkg::REG_W-1:0]    prdata,
	output logic                          pready,
	input  logic                          push,
	output logic                          full,
	input  vtpd_pkg::coord_t              in_x,
	input  vtpd_pkg::coord_t              in_y,
	input  vtpd_pkg::coord_t              in_z,
	output logic                          empty,
	input  logic                          pop,
	output vtpd_pkg::coord_t              out_x,
	output vtpd_pkg::coord_t              out_y,
	output vtpd_pkg::coord_t              out_z,
	output vtpd_pkg::coord_t              out_w,
	output logic                          zero_w
);
	import vtpd_pkg::*;

	localparam int unsigned MC_W = $clog2(MID_DEPTH+1);
	localparam int unsigned OC_W = $clog2(OUT_DEPTH+1);

	// ---- register file ----
	logic [REG_W-1:0] cfg_q [NUM_REGS];
	logic [IDX_W-1:0] reg_idx;
	logic             cfg_wr;
	mat_t             mat;

	assign reg_idx = paddr[ADDR_W-1:3];
	assign cfg_wr  = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign prdata  = cfg_q[reg_idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				cfg_q[i] <= REG_RESET[i];
			end
		end else if (cfg_wr) begin
			cfg_q[reg_idx] <= pwdata;
		end
	end

	// entry (r, c): register 2r + c/2, odd columns in the high half
	always_comb begin
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				mat[r][c] = cfg_q[IDX_W'(2*r + c/2)][(c%2)*COORD_W +: COORD_W];
			end
		end
	end

	// ---- front end and mid queue ----
	logic             accept;
	logic             front_vld;
	mid_word_t        front_word;
	logic [MC_W-1:0]  front_cnt_q;
	logic [MC_W-1:0]  mid_cnt;
	logic             mid_empty;
	logic [$bits(mid_word_t)-1:0] mid_rdata;
	logic             issue;

	// words in the front pipe plus words queued must leave room
	assign full   = (((MC_W+1)'(front_cnt_q) + (MC_W+1)'(mid_cnt)) >= (MC_W+1)'(MID_DEPTH))
		? 1'b1 : 1'b0;
	assign accept = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_cnt_q <= '0;
		end else if (accept && !front_vld) begin
			front_cnt_q <= front_cnt_q + MC_W'(1);
		end else if (front_vld && !accept) begin
			front_cnt_q <= front_cnt_q - MC_W'(1);
		end
	end

	vtpd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (accept),
		.in_x     (in_x),
		.in_y     (in_y),
		.in_z     (in_z),
		.mat      (mat),
		.out_vld  (front_vld),
		.out_word (front_word)
	);

	vtpd_fifo #(
		.DEPTH (MID_DEPTH),
		.WIDTH ($bits(mid_word_t))
	) u_mid_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (front_vld),
		.wr_data (front_word),
		.rd_en   (issue),
		.rd_data (mid_rdata),
		.empty   (mid_empty),
		.count   (mid_cnt)
	);

	// ---- back end and result queue ----
	logic             back_vld;
	out_word_t        back_word;
	logic [OC_W-1:0]  back_cnt_q;
	logic [OC_W-1:0]  out_cnt;
	logic             do_pop;
	out_word_t        res_word;
	logic [$bits(out_word_t)-1:0] out_rdata;

	assign issue  = !mid_empty
		&& (((OC_W+1)'(back_cnt_q) + (OC_W+1)'(out_cnt)) < (OC_W+1)'(OUT_DEPTH));
	assign do_pop = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			back_cnt_q <= '0;
		end else if (issue && !back_vld) begin
			back_cnt_q <= back_cnt_q + OC_W'(1);
		end else if (back_vld && !issue) begin
			back_cnt_q <= back_cnt_q - OC_W'(1);
		end
	end

	vtpd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (issue),
		.in_word  (mid_word_t'(mid_rdata)),
		.out_vld  (back_vld),
		.out_word (back_word)
	);

	vtpd_fifo #(
		.DEPTH (OUT_DEPTH),
		.WIDTH ($bits(out_word_t))
	) u_out_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (back_vld),
		.wr_data (back_word),
		.rd_en   (do_pop),
		.rd_data (out_rdata),
		.empty   (empty),
		.count   (out_cnt)
	);

	assign res_word = out_word_t'(out_rdata);
	assign out_x    = res_word.x;
	assign out_y    = res_word.y;
	assign out_z    = res_word.z;
	assign out_w    = res_word.w;
	assign zero_w   = res_word.zero;

	// ---- checks ----
	a_mid_room: assert property (@(posedge clk) disable iff (!arst_n)
		front_vld |-> (mid_cnt < MC_W'(MID_DEPTH)) || issue)
		else $error("mid queue written while full");

	a_out_room: assert property (@(posedge clk) disable iff (!arst_n)
		back_vld |-> (out_cnt < OC_W'(OUT_DEPTH)) || do_pop)
		else $error("result queue written while full");

	a_front_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		front_vld |-> front_cnt_q != '0)
		else $error("front credit count underflow");

	a_back_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		back_vld |-> back_cnt_q != '0)
		else $error("back credit count underflow");

	a_zero_w: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && zero_w) |-> (out_x == '0 && out_y == '0 && out_z == '0 && out_w == '0))
		else $error("zero w result with nonzero fields");

endmodule
